@@ rtl/assert_macros.svh @@
// Assertion macros used by the top level of the sliding median alert block.
// No dependencies; each use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define SMA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset
`define SMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/sma_pkg.sv @@
// Shared types and constants for the sliding median alert block.
// No dependencies.
package sma_pkg;

  // Fixed field widths
  localparam int CFG_BITS   = 7;
  localparam int COUNT_BITS = 32;

  // Window size after reset
  localparam logic [CFG_BITS-1:0] WINDOW_RESET = 7'd5;

  // Command to every cell of the sorted chain
  typedef struct packed {
    logic remove;   // drop first entry >= key, shift down from the right
    logic insert;   // insert key in order, shift up from the left
  } sma_cmd_t;

endpackage

@@ rtl/sma_cell.sv @@
// One slot of the sorted window chain.
// Depends on sma_pkg for the command struct.
module sma_cell #(
  parameter int VALUE_BITS = 16,
  parameter int CNT_BITS   = 7,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  sma_pkg::sma_cmd_t     cmd,
  input  logic [VALUE_BITS-1:0] key,
  input  logic [CNT_BITS-1:0]   bound,
  input  logic [VALUE_BITS-1:0] left_val,
  input  logic                  left_gt,
  input  logic [VALUE_BITS-1:0] right_val,
  output logic [VALUE_BITS-1:0] val,
  output logic                  gt
);
  import sma_pkg::*;

  localparam logic [CNT_BITS-1:0] MY_IDX = CNT_BITS'(IDX);

  logic [VALUE_BITS-1:0] val_r;
  logic [VALUE_BITS-1:0] val_nxt;
  logic                  active;
  logic                  at_end;
  logic                  ge;

  // Slot position against the live length
  assign active = (MY_IDX < bound);
  assign at_end = (MY_IDX == bound);
  assign gt     = active && (val_r > key);
  assign ge     = active && (val_r >= key);
  assign val    = val_r;

  // Remove: slots from the match upward take the right neighbor.
  // Insert: slots above key, plus the first free slot, take left or key.
  always_comb begin
    val_nxt = val_r;
    if (cmd.remove && ge) begin
      val_nxt = right_val;
    end else if (cmd.insert && (gt || at_end)) begin
      val_nxt = left_gt ? left_val : key;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

@@ rtl/sliding_median_alert_unit.sv @@
// Sliding median alert: top level with control, arrival ring and cell chain.
// Depends on sma_pkg, sma_cell and assert_macros.svh.
//
// Each accepted value is compared against twice the median of the last
// window_size values (1..WINDOW_MAX, 0 acts as 1, larger acts as WINDOW_MAX)
// once the window is full; the result carries the alert and a saturating
// alert count. A streaming value passes a result step, which reads the median
// off the sorted cell chain, builds the result and drops the oldest value,
// and an insert step, which puts the new value into the chain; the next
// value is taken as the insert step ends. The step that builds the result
// waits while the output register holds an untaken result. The oldest value
// comes from an arrival ring memory read at the edge that takes the value.
// Writing window_size empties the window but keeps the alert count; restart
// also clears the count. No clearing pass is needed after reset.
module sliding_median_alert_unit #(
  parameter int WINDOW_MAX = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [VALUE_BITS-1:0]        in_value,
  input  logic                         in_restart,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_window_full,
  output logic                         out_alert,
  output logic [sma_pkg::COUNT_BITS-1:0] out_alert_count,
  // configuration
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sma_pkg::CFG_BITS-1:0] cfg_window_size
);
  import sma_pkg::*;

  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_INS  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [CFG_BITS-1:0]   size_r;
  logic [CW-1:0]         fill_r, fill_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [VALUE_BITS-1:0] value_r;
  logic                  full_r;
  logic                  byp_r;
  logic [VALUE_BITS-1:0] byp_data_r;
  logic [VALUE_BITS-1:0] rd_data_r;
  logic [VALUE_BITS-1:0] ring_mem [WINDOW_MAX];

  logic                  out_valid_r;
  logic                  out_full_r;
  logic                  out_alert_r;
  logic [COUNT_BITS-1:0] out_count_r;

  logic [CW-1:0]         d_eff;
  logic                  in_xfer;
  logic                  cfg_xfer;
  logic                  out_free;
  logic                  calc_go;
  logic                  full;
  logic                  alert;
  logic [AW-1:0]         med_hi;
  logic [AW-1:0]         med_lo;
  logic [VALUE_BITS:0]   twice_med;
  logic [CW-1:0]         ptr_inc;
  logic [AW-1:0]         ptr_after;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  logic [VALUE_BITS-1:0] old_val;
  logic [CW-1:0]         ins_n;
  sma_cmd_t              cmd;
  logic [VALUE_BITS-1:0] key;
  logic [CW-1:0]         bound;
  logic [VALUE_BITS-1:0] cell_val [WINDOW_MAX];
  logic                  cell_gt  [WINDOW_MAX];

  // Effective window size
  always_comb begin
    if (size_r == '0) begin
      d_eff = CW'(1);
    end else if (32'(size_r) > 32'(WINDOW_MAX)) begin
      d_eff = CW'(WINDOW_MAX);
    end else begin
      d_eff = CW'(size_r);
    end
  end

  // Handshakes
  assign cfg_ready = (state_r == S_IDLE);
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign in_stall  = !(((state_r == S_IDLE) && !cfg_valid) || (state_r == S_INS));
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign calc_go   = (state_r == S_CALC) && out_free;

  // Median test off the sorted chain
  assign full   = (fill_r == d_eff);
  assign med_hi = AW'(d_eff >> 1);
  assign med_lo = d_eff[0] ? med_hi : (med_hi - AW'(1));
  assign twice_med = {1'b0, cell_val[med_hi]} + {1'b0, cell_val[med_lo]};
  assign alert  = full && ({1'b0, value_r} >= twice_med);

  // Ring pointer after this item's write
  assign ptr_inc   = CW'(ptr_r) + CW'(1);
  assign ptr_after = (ptr_inc >= d_eff) ? '0 : ptr_inc[AW-1:0];

  // Ring write in the insert step; read for the next item at its transfer
  assign wr_en   = (state_r == S_INS);
  assign wr_addr = full_r ? ptr_r : fill_r[AW-1:0];
  always_comb begin
    if (in_restart) begin
      rd_addr = '0;
    end else if ((state_r == S_INS) && full_r) begin
      rd_addr = ptr_after;
    end else begin
      rd_addr = ptr_r;
    end
  end
  assign old_val = byp_r ? byp_data_r : rd_data_r;

  // Next-state and counters
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    ptr_nxt   = ptr_r;
    count_nxt = count_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) state_nxt = S_CALC;
      end
      S_CALC: begin
        if (calc_go) begin
          state_nxt = S_INS;
          if (alert && (count_r != '1)) count_nxt = count_r + COUNT_BITS'(1);
        end
      end
      S_INS: begin
        state_nxt = in_xfer ? S_CALC : S_IDLE;
        if (full_r) begin
          ptr_nxt = ptr_after;
        end else begin
          fill_nxt = fill_r + CW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (in_xfer && in_restart) begin
      fill_nxt  = '0;
      ptr_nxt   = '0;
      count_nxt = '0;
    end
    if (cfg_xfer) begin
      fill_nxt = '0;
      ptr_nxt  = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= WINDOW_RESET;
      fill_r      <= '0;
      ptr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      byp_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      ptr_r   <= ptr_nxt;
      count_r <= count_nxt;
      if (cfg_xfer) size_r <= cfg_window_size;
      if (calc_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_xfer) byp_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      value_r    <= in_value;
      byp_data_r <= value_r;
    end
    if (calc_go) begin
      full_r      <= full;
      out_full_r  <= full;
      out_alert_r <= alert;
      out_count_r <= count_nxt;
    end
  end

  // Arrival ring memory
  always_ff @(posedge clk) begin
    if (wr_en) ring_mem[wr_addr] <= value_r;
    if (in_xfer) rd_data_r <= ring_mem[rd_addr];
  end

  // Chain control: remove the oldest in the result step, then insert
  assign ins_n      = full_r ? (d_eff - CW'(1)) : fill_r;
  assign cmd.remove = calc_go && full;
  assign cmd.insert = (state_r == S_INS);
  assign key        = cmd.insert ? value_r : old_val;
  assign bound      = cmd.insert ? ins_n : d_eff;

  // Sorted cell chain
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left_v;
    logic                  left_g;
    logic [VALUE_BITS-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
      assign left_g = 1'b0;
    end else begin : g_mid
      assign left_v = cell_val[i-1];
      assign left_g = cell_gt[i-1];
    end
    if (i == WINDOW_MAX - 1) begin : g_last
      assign right_v = cell_val[i];
    end else begin : g_inner
      assign right_v = cell_val[i+1];
    end
    sma_cell #(
      .VALUE_BITS (VALUE_BITS),
      .CNT_BITS   (CW),
      .IDX        (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .key       (key),
      .bound     (bound),
      .left_val  (left_v),
      .left_gt   (left_g),
      .right_val (right_v),
      .val       (cell_val[i]),
      .gt        (cell_gt[i])
    );
  end

  // Outputs
  assign out_valid       = out_valid_r;
  assign out_window_full = out_full_r;
  assign out_alert       = out_alert_r;
  assign out_alert_count = out_count_r;

  // Checks
`include "assert_macros.svh"
  `SMA_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= d_eff)
  `SMA_ASSERT_NOW(a_ptr_bound, 1'b1, CW'(ptr_r) < d_eff)
  `SMA_ASSERT_NEXT(a_xfer_calc, in_xfer, state_r == S_CALC)
  `SMA_ASSERT_NOW(a_alert_full, out_valid_r && out_alert_r, out_full_r)

endmodule
